>>> hdl/bcmd_pkg.sv
// ----------------------------------------------------------------------------
// Battery compensated motor duty: shared definitions
// Command, record-kind and register index codes, field widths and the
// status record that each motor lane hands back to the top level.
// ----------------------------------------------------------------------------
package bcmd_pkg;

   localparam int unsigned TGT_W  = 16;  // signed millivolt target
   localparam int unsigned MV_W   = 16;  // battery and threshold in millivolts
   localparam int unsigned LIM_W  = 15;  // clamp magnitude
   localparam int unsigned DUTY_W = 16;  // PWM duty
   localparam int unsigned PCT_W  = 8;   // signed telemetry percent

   // Command codes carried on req_tuser.
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_BRAKE = 2'd1;
   localparam logic [1:0] CMD_COAST = 2'd2;
   localparam logic [1:0] CMD_RSVD  = 2'd3;

   // Register indexes on the CSR port.
   localparam logic [2:0] CSR_ENABLED   = 3'd0;
   localparam logic [2:0] CSR_MAX_CMD   = 3'd1;
   localparam logic [2:0] CSR_PWM_FS    = 3'd2;
   localparam logic [2:0] CSR_LEFT_REV  = 3'd3;
   localparam logic [2:0] CSR_RIGHT_REV = 3'd4;
   localparam logic [2:0] CSR_LOW_BAT   = 3'd5;

   // Register reset values.
   localparam logic [LIM_W-1:0]  MAX_CMD_RST = 15'd6000;
   localparam logic [DUTY_W-1:0] PWM_FS_RST  = 16'd1023;
   localparam logic [MV_W-1:0]   LOW_BAT_RST = 16'd3000;

   // What an accepted transaction does to the bridge state.
   localparam logic [2:0] KIND_HOLD  = 3'd0;  // disabled or reserved command
   localparam logic [2:0] KIND_BRAKE = 3'd1;
   localparam logic [2:0] KIND_COAST = 3'd2;
   localparam logic [2:0] KIND_LOW   = 3'd3;  // set command under low battery
   localparam logic [2:0] KIND_DRIVE = 3'd4;  // set command, lanes compute

   localparam logic [6:0] PCT_SCALE = 7'd100;

   typedef struct packed {
      logic                     done;
      logic [DUTY_W-1:0]        in1;
      logic [DUTY_W-1:0]        in2;
      logic signed [PCT_W-1:0]  pct;
   } side_res_type;

endpackage

>>> hdl/bcmd_side.sv
// ----------------------------------------------------------------------------
// Battery compensated motor duty: one motor lane
// Clamps and orients one target, then computes the duty and the percent
// with a bit-serial multiplier and a shared restoring divider.
// ----------------------------------------------------------------------------
module bcmd_side (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [bcmd_pkg::TGT_W-1:0]  target,
   input  logic                               reversed,
   input  logic [bcmd_pkg::LIM_W-1:0]         lim,
   input  logic [bcmd_pkg::DUTY_W-1:0]        pfs,
   input  logic [bcmd_pkg::MV_W-1:0]          bat,
   output bcmd_pkg::side_res_type             res
);
   import bcmd_pkg::*;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_MUL  = 3'd1;
   localparam logic [2:0] P_DIV  = 3'd2;
   localparam logic [2:0] P_SAT  = 3'd3;
   localparam logic [2:0] P_PCT  = 3'd4;
   localparam logic [2:0] P_DONE = 3'd5;

   localparam int unsigned PROD_W = LIM_W + DUTY_W;  // 31 bits
   localparam int unsigned PCTD_W = DUTY_W + 7;      // duty * 100

   logic [2:0]             phase_ff, phase_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [LIM_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic [MV_W-1:0]        bat_ff, bat_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [DUTY_W-1:0]      rem_ff, rem_in;
   logic [DUTY_W-1:0]      quo_ff, quo_in;
   logic                   ovf_ff, ovf_in;
   logic [DUTY_W-1:0]      duty_ff, duty_in;

   logic signed [TGT_W:0]  t_ext, lim_s, t_clamp, t_dir, t_abs;
   logic [DUTY_W-1:0]      divisor;
   logic [DUTY_W:0]        trial;
   logic [DUTY_W+1:0]      diff;
   logic                   fits;
   logic [DUTY_W-1:0]      rem_step;
   logic [DUTY_W-1:0]      duty_sat;
   logic [PCTD_W-1:0]      pct_dividend;
   logic [6:0]             pct_mag;

   // Clamp and direction, evaluated on the start cycle.
   always_comb begin
      t_ext = (TGT_W+1)'(target);
      lim_s = $signed({2'b00, lim});
      if (t_ext > lim_s) begin
         t_clamp = lim_s;
      end else if (t_ext < -lim_s) begin
         t_clamp = -lim_s;
      end else begin
         t_clamp = t_ext;
      end
      t_dir = reversed ? -t_clamp : t_clamp;
      t_abs = t_dir[TGT_W] ? -t_dir : t_dir;
   end

   // One restoring divide step: duty uses the battery, percent the full scale.
   always_comb begin
      divisor  = (phase_ff == P_DIV) ? bat_ff : pfs;
      trial    = {rem_ff, prod_ff[PROD_W-1]};
      diff     = {1'b0, trial} - {2'b00, divisor};
      fits     = !diff[DUTY_W+1];
      rem_step = fits ? diff[DUTY_W-1:0] : trial[DUTY_W-1:0];
   end

   always_comb begin
      duty_sat     = (ovf_ff || quo_ff > pfs) ? pfs : quo_ff;
      pct_dividend = PCTD_W'(duty_sat) * PCTD_W'(PCT_SCALE);
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      bat_in   = bat_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      duty_in  = duty_ff;
      if (start) begin
         phase_in = P_MUL;
         cnt_in   = 5'(LIM_W - 1);
         mag_in   = t_abs[LIM_W-1:0];
         neg_in   = t_dir[TGT_W];
         zero_in  = (t_dir == '0);
         bat_in   = bat;
         prod_in  = '0;
      end else begin
         unique case (phase_ff)
            P_MUL: begin
               prod_in = {prod_ff[PROD_W-2:0], 1'b0}
                         + (mag_ff[LIM_W-1] ? PROD_W'(pfs) : '0);
               mag_in  = {mag_ff[LIM_W-2:0], 1'b0};
               cnt_in  = cnt_ff - 5'd1;
               if (cnt_ff == '0) begin
                  phase_in = P_DIV;
                  cnt_in   = 5'(PROD_W - 1);
                  rem_in   = '0;
                  quo_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
            P_DIV, P_PCT: begin
               prod_in = {prod_ff[PROD_W-2:0], 1'b0};
               rem_in  = rem_step;
               quo_in  = {quo_ff[DUTY_W-2:0], fits};
               ovf_in  = ovf_ff | quo_ff[DUTY_W-1];
               cnt_in  = cnt_ff - 5'd1;
               if (cnt_ff == '0) begin
                  phase_in = (phase_ff == P_DIV) ? P_SAT : P_DONE;
               end
            end
            P_SAT: begin
               duty_in  = duty_sat;
               prod_in  = {pct_dividend, {(PROD_W-PCTD_W){1'b0}}};
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = 5'(PCTD_W - 1);
               phase_in = P_PCT;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      bat_ff  <= bat_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
      duty_ff <= duty_in;
   end

   // A zero full scale makes the percent divide meaningless; the percent is 0.
   always_comb begin
      pct_mag  = (pfs == '0 || zero_ff) ? 7'd0 : quo_ff[6:0];
      res.done = (phase_ff == P_DONE);
      res.in1  = (!neg_ff && !zero_ff) ? duty_ff : '0;
      res.in2  = (neg_ff && !zero_ff) ? duty_ff : '0;
      res.pct  = neg_ff ? -$signed({1'b0, pct_mag}) : $signed({1'b0, pct_mag});
   end

endmodule

>>> hdl/battery_compensated_motor_duty_core.sv
// ----------------------------------------------------------------------------
// Battery compensated motor duty core
// Turns set, brake and coast commands for two H-bridge motors into four pin
// duties and two telemetry percents, scaling each target by the battery.
// ----------------------------------------------------------------------------
// For a set transaction each motor lane runs a bit-serial multiply of the
// clamped target by the full scale, a restoring divide by the battery
// voltage, a saturation step and a second divide that yields the
// percent, and both lanes run side by side. Brake, coast, low battery
// and ignored transactions skip the lanes. A finished result sits in the
// response register while the next request is already accepted and
// computed; the bridge state only advances when a result moves into that
// register, so a stalled response never loses or reorders anything.
// Configuration registers must be written through the CSR port only while
// the core is idle; the core itself does not enforce this. They take effect
// for the next transaction.
module battery_compensated_motor_duty_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] left_target_mv, [31:16] right_target_mv, [47:32] battery_mv
   input  logic [47:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] left_in1_duty, [31:16] left_in2_duty, [47:32] right_in1_duty,
   // [63:48] right_in2_duty, [71:64] left_percent, [79:72] right_percent
   output logic [79:0] rsp_tdata,
   // [0] accepted, [1] battery_low
   output logic [1:0]  rsp_tuser,
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bcmd_pkg::*;

   // Configuration registers.
   logic                 enabled_ff;
   logic [LIM_W-1:0]     max_cmd_ff;
   logic [DUTY_W-1:0]    pwm_fs_ff;
   logic                 left_rev_ff;
   logic                 right_rev_ff;
   logic [MV_W-1:0]      low_bat_ff;

   // Control.
   logic                 busy_ff, busy_in;
   logic [2:0]           kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Bridge state, which is also the response payload.
   logic [DUTY_W-1:0]       pin_ff [4];
   logic signed [PCT_W-1:0] pct_ff [2];
   logic                    acc_ff;
   logic                    low_ff;

   logic                    req_fire;
   logic                    res_ready;
   logic                    xfer;
   logic                    start_lanes;
   logic [1:0]              cmd;
   logic signed [TGT_W-1:0] left_tgt;
   logic signed [TGT_W-1:0] right_tgt;
   logic [MV_W-1:0]         bat;
   logic                    bat_low;

   side_res_type            left_res;
   side_res_type            right_res;

   assign cmd       = req_tuser;
   assign left_tgt  = $signed(req_tdata[15:0]);
   assign right_tgt = $signed(req_tdata[31:16]);
   assign bat       = req_tdata[47:32];

   // One transaction is in flight at a time; the response register is separate.
   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;

   // An empty battery counts as low whatever the threshold says, so a set command coasts.
   assign bat_low = (bat == '0) || (bat < low_bat_ff);

   always_comb begin
      if (!enabled_ff || cmd == CMD_RSVD) begin
         kind_in = KIND_HOLD;
      end else begin
         unique case (cmd)
            CMD_BRAKE: kind_in = KIND_BRAKE;
            CMD_COAST: kind_in = KIND_COAST;
            default:   kind_in = bat_low ? KIND_LOW : KIND_DRIVE;
         endcase
      end
   end

   assign start_lanes = req_fire && (kind_in == KIND_DRIVE);

   bcmd_side u_left (
      .clock    (clock),
      .reset    (reset),
      .start    (start_lanes),
      .target   (left_tgt),
      .reversed (left_rev_ff),
      .lim      (max_cmd_ff),
      .pfs      (pwm_fs_ff),
      .bat      (bat),
      .res      (left_res)
   );

   bcmd_side u_right (
      .clock    (clock),
      .reset    (reset),
      .start    (start_lanes),
      .target   (right_tgt),
      .reversed (right_rev_ff),
      .lim      (max_cmd_ff),
      .pfs      (pwm_fs_ff),
      .bat      (bat),
      .res      (right_res)
   );

   // The result of the transaction in flight moves into the response register
   // as soon as it is known and the register is free or being emptied.
   assign res_ready = busy_ff && ((kind_ff != KIND_DRIVE) || (left_res.done && right_res.done));
   assign xfer      = res_ready && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (xfer) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_HOLD;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            kind_ff <= kind_in;
         end
      end
   end

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         max_cmd_ff   <= MAX_CMD_RST;
         pwm_fs_ff    <= PWM_FS_RST;
         left_rev_ff  <= 1'b0;
         right_rev_ff <= 1'b0;
         low_bat_ff   <= LOW_BAT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLED:   enabled_ff   <= csr_wdata[0];
            CSR_MAX_CMD:   max_cmd_ff   <= csr_wdata[LIM_W-1:0];
            CSR_PWM_FS:    pwm_fs_ff    <= csr_wdata;
            CSR_LEFT_REV:  left_rev_ff  <= csr_wdata[0];
            CSR_RIGHT_REV: right_rev_ff <= csr_wdata[0];
            CSR_LOW_BAT:   low_bat_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Bridge state update. A held transaction keeps pins and percents and
   // reports accepted and battery_low as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pin_ff[i] <= '0;
         end
         pct_ff[0] <= '0;
         pct_ff[1] <= '0;
         acc_ff    <= 1'b0;
         low_ff    <= 1'b0;
      end else if (xfer) begin
         acc_ff <= (kind_ff != KIND_HOLD);
         low_ff <= (kind_ff == KIND_LOW);
         unique case (kind_ff)
            KIND_BRAKE: begin
               for (int i = 0; i < 4; i++) begin
                  pin_ff[i] <= pwm_fs_ff;
               end
               pct_ff[0] <= '0;
               pct_ff[1] <= '0;
            end
            KIND_COAST, KIND_LOW: begin
               for (int i = 0; i < 4; i++) begin
                  pin_ff[i] <= '0;
               end
               pct_ff[0] <= '0;
               pct_ff[1] <= '0;
            end
            KIND_DRIVE: begin
               pin_ff[0] <= left_res.in1;
               pin_ff[1] <= left_res.in2;
               pin_ff[2] <= right_res.in1;
               pin_ff[3] <= right_res.in2;
               pct_ff[0] <= left_res.pct;
               pct_ff[1] <= right_res.pct;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pct_ff[1], pct_ff[0], pin_ff[3], pin_ff[2], pin_ff[1], pin_ff[0]};
   assign rsp_tuser  = {low_ff, acc_ff};

   // Both lanes start together and take the same number of cycles.
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && kind_ff == KIND_DRIVE && left_res.done) |-> right_res.done)
      else $error("motor lanes finished out of step");

   // A low battery flag only comes with an applied command.
   a_low_needs_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && low_ff) |-> acc_ff)
      else $error("battery_low reported on an ignored command");

   // Telemetry percents stay within one hundred.
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pct_ff[0] <= 8'sd100 && pct_ff[0] >= -8'sd100 &&
                        pct_ff[1] <= 8'sd100 && pct_ff[1] >= -8'sd100))
      else $error("duty percent out of range");

   // No new request is taken in the cycle after one was accepted.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second transaction accepted while one is in flight");

endmodule
